[sv/rc_receiver_frame_parser_macros.svh]
// assertion macros for the rc receiver frame parser
`ifndef RC_RECEIVER_FRAME_PARSER_MACROS_SVH
`define RC_RECEIVER_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define RCFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define RCFP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define RCFP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RCFP_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

[sv/rcfp_pkg.sv]
package rcfp_pkg;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_TIMEOUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [10:0] position;
      logic [4:0]  channel_id;
      logic        id_ok;
      logic [3:0]  slot;
      logic        last_word;
      logic        frame_ok;
   } rsp_type;

   localparam logic [7:0] HEADER_RESET = 8'hA2;
   localparam int         ID_LSB       = 11;

   // register word index decoded from paddr[2]
   localparam logic       CSR_HEADER_IDX = 1'b0;

endpackage

[sv/rc_receiver_frame_parser.sv]
// a result is formed when its low byte is accepted and is registered in the output buffer before it shows on rsp_valid
// throughput: one byte per cycle; the two-entry output buffer keeps req_ready high
// unless a result is parked behind a stalled output
// reset (synchronous, active high): back to header hunt, output buffer emptied,
// header register set to 0xA2
`include "rc_receiver_frame_parser_macros.svh"

module rc_receiver_frame_parser #(
   parameter int CHANNELS = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcfp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic              header_ff;
   logic [7:0]        header_byte_ff, header_byte_in;
   logic              req_accept;
   logic              res_valid;
   rcfp_pkg::rsp_type res_data;

   assign csr_pready = 1'b1;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      header_byte_in = header_byte_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == rcfp_pkg::CSR_HEADER_IDX) begin
         header_byte_in = csr_pwdata[7:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == rcfp_pkg::CSR_HEADER_IDX) begin
         csr_prdata = {24'd0, header_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= rcfp_pkg::HEADER_RESET;
      end else begin
         header_byte_ff <= header_byte_in;
      end
   end

   // bookkeeping used only by the checks: header_ff mirrors a completed frame
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         header_ff <= rsp_data.last_word;
      end
   end

   rcfp_parser #(
      .CHANNELS (CHANNELS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_data   (req_data),
      .header    (header_byte_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   rcfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_ready),
      .in_data   (res_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   `RCFP_ASSERT_IMPLY(a_frame_ok_on_last, clock, reset, rsp_valid && rsp_data.frame_ok, rsp_data.last_word && rsp_data.id_ok && rsp_data.slot == 4'(CHANNELS - 1))
   `RCFP_ASSERT_NEVER(a_slot_in_range, clock, reset, rsp_valid && rsp_data.slot >= 4'(CHANNELS))
   `RCFP_ASSERT_IMPLY(a_stall_only_behind_result, clock, reset, !req_ready, rsp_valid)
   `RCFP_ASSERT_IMPLY(a_frame_end_seen, clock, reset, header_ff && rsp_valid, rsp_data.slot == 4'd0)

endmodule

[sv/rcfp_parser.sv]
module rcfp_parser #(
   parameter int CHANNELS = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  rcfp_pkg::req_type in_data,
   input  logic [7:0]       header,
   output logic             res_valid,
   output rcfp_pkg::rsp_type res_data
);

   localparam int FrameBytes = 2 * CHANNELS;

   logic       in_frame_ff, in_frame_in;
   logic [4:0] byte_index_ff, byte_index_in;
   logic [7:0] high_byte_ff, high_byte_in;
   logic [3:0] count_ff, count_in;

   logic [15:0] word;
   logic [4:0]  idx_inc;
   logic        last;
   logic        ok;

   always_comb begin
      word     = {high_byte_ff, in_data.rx_byte};
      idx_inc  = byte_index_ff + 5'd1;
      last     = idx_inc >= 5'(FrameBytes);
      ok       = word[15:rcfp_pkg::ID_LSB] < 5'(CHANNELS);

      res_data.position   = word[rcfp_pkg::ID_LSB-1:0];
      res_data.channel_id = word[15:rcfp_pkg::ID_LSB];
      res_data.id_ok      = ok;
      res_data.slot       = count_ff;
      res_data.last_word  = last;
      res_data.frame_ok   = last && (({1'b0, count_ff} + 5'(ok)) == 5'(CHANNELS));

      in_frame_in   = in_frame_ff;
      byte_index_in = byte_index_ff;
      high_byte_in  = high_byte_ff;
      count_in      = count_ff;
      res_valid     = 1'b0;

      if (in_accept) begin
         if (in_data.op == rcfp_pkg::OP_TIMEOUT) begin
            in_frame_in   = 1'b0;
            byte_index_in = '0;
            high_byte_in  = '0;
            count_in      = '0;
         end else if (!in_frame_ff) begin
            // hunting for the header, everything else is dropped
            if (in_data.rx_byte == header) begin
               in_frame_in   = 1'b1;
               byte_index_in = '0;
               high_byte_in  = '0;
               count_in      = '0;
            end
         end else if (!byte_index_ff[0]) begin
            high_byte_in  = in_data.rx_byte;
            byte_index_in = idx_inc;
         end else begin
            res_valid     = 1'b1;
            byte_index_in = idx_inc;
            if (ok) begin
               count_in = count_ff + 4'd1;
            end
            if (last) begin
               in_frame_in   = 1'b0;
               byte_index_in = '0;
               high_byte_in  = '0;
               count_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_index_ff <= '0;
         high_byte_ff  <= '0;
         count_ff      <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         byte_index_ff <= byte_index_in;
         high_byte_ff  <= high_byte_in;
         count_ff      <= count_in;
      end
   end

endmodule

[sv/rcfp_out_buf.sv]
module rcfp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcfp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rcfp_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rcfp_pkg::rsp_type main_ff, main_in;
   rcfp_pkg::rsp_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         // output stalled, park the new item
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
